// ===== sv/ucf_pkg.sv =====
// Package for the UTF-8 decoder with Windows-1252 fallback.
// Holds byte-class constants, codepoint offsets and the 1252 upper-half map.
// No dependencies.
package ucf_pkg;

    // Widths
    localparam int unsigned CP_W  = 21;
    localparam int unsigned SUM_W = 27;

    // Lead and continuation byte limits
    localparam logic [7:0] B_ASCII_END = 8'h80;
    localparam logic [7:0] B_LEAD_MIN  = 8'hC1;
    localparam logic [7:0] B_LEAD3     = 8'hE0;
    localparam logic [7:0] B_LEAD_ED   = 8'hED;
    localparam logic [7:0] B_LEAD4     = 8'hF0;
    localparam logic [7:0] B_LEAD_F4   = 8'hF4;
    localparam logic [7:0] B_LEAD_END  = 8'hF5;
    localparam logic [7:0] B_HI_9F     = 8'h9F;
    localparam logic [7:0] B_HI_8F     = 8'h8F;
    localparam logic [7:0] B_HI_90     = 8'h90;
    localparam logic [7:0] B_CONT_MASK = 8'hC0;
    localparam logic [7:0] B_CONT_TAG  = 8'h80;

    // Offsets that remove the UTF-8 tag bits after the shifted sum
    localparam logic [SUM_W-1:0] CP2_OFS = 27'h0003080;
    localparam logic [SUM_W-1:0] CP3_OFS = 27'h00E2080;
    localparam logic [SUM_W-1:0] CP4_OFS = 27'h3C82080;

    // Windows-1252 codepoints for bytes 80-9F
    localparam logic [15:0] CP1252_HIGH [0:31] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    // Map one raw byte through Windows-1252
    function automatic logic [CP_W-1:0] map_cp1252(input logic [7:0] b);
        logic [CP_W-1:0] cp;
        if (b[7:5] == 3'b100) begin
            cp = {5'b0, CP1252_HIGH[b[4:0]]};
        end else begin
            cp = {13'b0, b};
        end
        return cp;
    endfunction

endpackage

// ===== sv/utf8_decode_cp1252_fallback.sv =====
// A result passes from its input transfer through the drain stage to the output register.
// Throughput: one input per cycle while each input gives at most one result and the
// output is not stalled; an input that flushes n buffered bytes (n from 1 to 3) holds
// the single-result drain stage until those bytes, and any result after them, are out.
// Input waits for that stage. Reset (i_rst_n low, synchronous) empties the
// pending buffer, the drain stage and the output register.
// Top level of the UTF-8 decoder with Windows-1252 fallback; uses ucf_pkg.
module utf8_decode_cp1252_fallback
    import ucf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_stream,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CP_W-1:0] o_codepoint,
    output logic            o_from_fallback,
    output logic            o_end_marker,
    output logic            o_last_of_run
);

    // Decoder state
    logic [7:0] r_pb [0:2];
    logic [1:0] r_pc;
    logic [7:0] n_pb [0:2];
    logic [1:0] n_pc;

    // Drain stage: buffered bytes to flush, then an optional tail result
    logic [7:0]      r_jb_byte [0:2];
    logic [1:0]      r_jb_nf;
    logic [1:0]      r_jb_pos;
    logic            r_jt_valid;
    logic [CP_W-1:0] r_jt_cp;
    logic            r_jt_fb;
    logic            r_jt_end;

    // Output register
    logic            r_o_valid;
    logic [CP_W-1:0] r_o_cp;
    logic            r_o_fb;
    logic            r_o_end;
    logic            r_o_last;

    // Load values for the drain stage
    logic [1:0]      ld_nf;
    logic            ld_tv;
    logic [CP_W-1:0] ld_cp;
    logic            ld_fb;
    logic            ld_end;

    logic            in_xfer;
    logic            out_adv;
    logic            job_empty;
    logic            job_last;
    logic            job_move;

    logic [7:0]      b;
    logic [7:0]      lead;
    logic            is_ascii;
    logic            lead_ok;
    logic            cont;
    logic            complete;
    logic [SUM_W-1:0] c2, c3, c4;
    logic [CP_W-1:0] seq_cp;

    logic [CP_W-1:0] dr_cp;
    logic            dr_fb;
    logic            dr_end;
    logic            dr_last;

    // Handshake
    assign job_empty  = (r_jb_nf == 2'd0) && !r_jt_valid;
    assign job_last   = ((r_jb_nf == 2'd0) && r_jt_valid) || ((r_jb_nf == 2'd1) && !r_jt_valid);
    assign out_adv    = !r_o_valid || i_out_ready;
    assign job_move   = !job_empty && out_adv;
    assign o_in_ready = job_empty || (job_last && out_adv);
    assign in_xfer    = i_in_valid && o_in_ready;

    // Byte classification
    assign b        = i_data_byte;
    assign lead     = r_pb[0];
    assign is_ascii = b < B_ASCII_END;
    assign lead_ok  = (b > B_LEAD_MIN) && (b < B_LEAD_END);

    always_comb begin
        cont = (b & B_CONT_MASK) == B_CONT_TAG;
        if (r_pc == 2'd1) begin
            if (lead == B_LEAD3   && b <= B_HI_9F) cont = 1'b0;
            if (lead == B_LEAD_ED && b >  B_HI_9F) cont = 1'b0;
            if (lead == B_LEAD4   && b <= B_HI_8F) cont = 1'b0;
            if (lead == B_LEAD_F4 && b >= B_HI_90) cont = 1'b0;
        end
    end

    assign complete = ((lead < B_LEAD3) && (r_pc == 2'd1))
                   || ((lead >= B_LEAD3) && (lead < B_LEAD4) && (r_pc == 2'd2))
                   || ((lead >= B_LEAD4) && (r_pc == 2'd3));

    // Codepoint assembly for a finished sequence
    assign c2 = {13'b0, lead, 6'b0} + {19'b0, b} - CP2_OFS;
    assign c3 = {7'b0, lead, 12'b0} + {13'b0, r_pb[1], 6'b0} + {19'b0, b} - CP3_OFS;
    assign c4 = {1'b0, lead, 18'b0} + {7'b0, r_pb[1], 12'b0} + {13'b0, r_pb[2], 6'b0}
              + {19'b0, b} - CP4_OFS;

    always_comb begin
        if (lead < B_LEAD3) begin
            seq_cp = c2[CP_W-1:0];
        end else if (lead < B_LEAD4) begin
            seq_cp = c3[CP_W-1:0];
        end else begin
            seq_cp = c4[CP_W-1:0];
        end
    end

    // Next decoder state and drain-stage load
    always_comb begin
        n_pc   = r_pc;
        n_pb   = r_pb;
        ld_nf  = 2'd0;
        ld_tv  = 1'b0;
        ld_cp  = '0;
        ld_fb  = 1'b0;
        ld_end = 1'b0;
        priority if (i_end_of_stream) begin
            n_pc   = 2'd0;
            ld_nf  = r_pc;
            ld_tv  = 1'b1;
            ld_end = 1'b1;
        end else if (r_pc == 2'd0 || !cont) begin
            // fresh byte (lead, ASCII or fallback byte), after flushing whatever was buffered
            ld_nf = r_pc;
            if (lead_ok) begin
                n_pb[0] = b;
                n_pc    = 2'd1;
            end else begin
                n_pc  = 2'd0;
                ld_tv = 1'b1;
                ld_cp = is_ascii ? {13'b0, b} : map_cp1252(b);
                ld_fb = !is_ascii;
            end
        end else if (complete) begin
            n_pc  = 2'd0;
            ld_tv = 1'b1;
            ld_cp = seq_cp;
        end else begin
            n_pb[r_pc] = b;
            n_pc       = r_pc + 2'd1;
        end
    end

    // Pending buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 2'd0;
        end else if (in_xfer) begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pb <= n_pb;
        end
    end

    // Drain stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jb_nf    <= 2'd0;
            r_jb_pos   <= 2'd0;
            r_jt_valid <= 1'b0;
        end else if (in_xfer) begin
            r_jb_nf    <= ld_nf;
            r_jb_pos   <= 2'd0;
            r_jt_valid <= ld_tv;
        end else if (job_move) begin
            if (r_jb_nf != 2'd0) begin
                r_jb_nf  <= r_jb_nf - 2'd1;
                r_jb_pos <= r_jb_pos + 2'd1;
            end else begin
                r_jt_valid <= 1'b0;
            end
        end
    end

    // Drain stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_jb_byte <= r_pb;
            r_jt_cp   <= ld_cp;
            r_jt_fb   <= ld_fb;
            r_jt_end  <= ld_end;
        end
    end

    // Current drain result: flushed bytes first, then the tail
    always_comb begin
        if (r_jb_nf != 2'd0) begin
            dr_cp   = map_cp1252(r_jb_byte[r_jb_pos]);
            dr_fb   = 1'b1;
            dr_end  = 1'b0;
            dr_last = (r_jb_nf == 2'd1) && !r_jt_valid;
        end else begin
            dr_cp   = r_jt_cp;
            dr_fb   = r_jt_fb;
            dr_end  = r_jt_end;
            dr_last = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (job_move) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_move) begin
            r_o_cp   <= dr_cp;
            r_o_fb   <= dr_fb;
            r_o_end  <= dr_end;
            r_o_last <= dr_last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_codepoint     = r_o_cp;
    assign o_from_fallback = r_o_fb;
    assign o_end_marker    = r_o_end;
    assign o_last_of_run   = r_o_last;

endmodule

// ===== sv/ucf_checker.sv =====
// Port-level checker for the UTF-8 decoder with Windows-1252 fallback.
// Uses ucf_pkg; bound to the top level at the end of this file.
module ucf_checker
    import ucf_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic [7:0]      i_data_byte,
    input logic            i_end_of_stream,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [CP_W-1:0] o_codepoint,
    input logic            o_from_fallback,
    input logic            o_end_marker,
    input logic            o_last_of_run
);

    // Waiting input transfer stays offered with the same payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_data_byte) && $stable(i_end_of_stream))
        else $error("input transfer withdrawn or changed while waiting");

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_codepoint) && $stable(o_from_fallback)
            && $stable(o_end_marker) && $stable(o_last_of_run))
        else $error("result payload changed while stalled");

    // End marker is the last, empty, non-fallback result of its input
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_marker |->
            o_last_of_run && !o_from_fallback && (o_codepoint == '0))
        else $error("malformed end marker");

    // Only flushed bytes can be followed by more results of the same input
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |->
            o_from_fallback && !o_end_marker && (o_codepoint[CP_W-1:16] == '0))
        else $error("non-final result that is not a flushed byte");

endmodule

bind utf8_decode_cp1252_fallback ucf_checker u_ucf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_data_byte     (i_data_byte),
    .i_end_of_stream (i_end_of_stream),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_codepoint     (o_codepoint),
    .o_from_fallback (o_from_fallback),
    .o_end_marker    (o_end_marker),
    .o_last_of_run   (o_last_of_run)
);

// ===== bench/utf8_decode_cp1252_fallback_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf8_decode_cp1252_fallback: byte driver, result monitor and
// a decode predictor with its own pending-byte state. Depends on ucf_pkg and the RTL.
module utf8_decode_cp1252_fallback_tb;
    import ucf_pkg::*;

    localparam int PHASE_ITEMS = 96;
    localparam int HOLD_AT     = 56;
    localparam int HOLD_LEN    = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        idle_mode_e mode;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            fb;
        logic            em;
        logic            last;
    } cp_result_t;

    // Windows-1252 upper half, bytes 80-9F
    localparam logic [15:0] WIN1252_HI [0:31] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [7:0]      in_byte = 8'h00;
    logic            in_eos = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [CP_W-1:0] out_cp;
    logic            out_fb;
    logic            out_em;
    logic            out_last;

    byte_item_t  byte_q[$];
    cp_result_t  cp_due_q[$];
    idle_mode_e  idle_mode = IDLE_NONE;
    int          n_taken = 0;
    int          n_err = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          cyc = 0;

    // Predictor state
    logic [7:0]  pend_b [0:2];
    logic [1:0]  pend_n = 2'd0;
    cp_result_t  run_buf [0:3];
    int          run_n;

    utf8_decode_cp1252_fallback u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (in_byte),
        .i_end_of_stream (in_eos),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_codepoint     (out_cp),
        .o_from_fallback (out_fb),
        .o_end_marker    (out_em),
        .o_last_of_run   (out_last)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- decode predictor ----------------

    function automatic logic [CP_W-1:0] cp1252_of(logic [7:0] b);
        if (b >= B_ASCII_END && b <= B_HI_9F)
            return {5'b0, WIN1252_HI[b[4:0]]};
        return {13'b0, b};
    endfunction

    function automatic void put_cp(logic [CP_W-1:0] cp, logic fb, logic em);
        run_buf[run_n] = '{cp: cp, fb: fb, em: em, last: 1'b0};
        run_n++;
    endfunction

    // Pending bytes go out one by one through the 1252 map
    function automatic void flush_pend();
        for (int i = 0; i < pend_n; i++)
            put_cp(cp1252_of(pend_b[i]), 1'b1, 1'b0);
        pend_n = 2'd0;
    endfunction

    function automatic void take_lead(logic [7:0] b);
        if (b < B_ASCII_END) begin
            put_cp({13'b0, b}, 1'b0, 1'b0);
        end else if (b > B_LEAD_MIN && b < B_LEAD_END) begin
            pend_b[0] = b;
            pend_n    = 2'd1;
        end else begin
            put_cp(cp1252_of(b), 1'b1, 1'b0);
        end
    endfunction

    // Continuation byte check; second byte has tighter limits after some leads
    function automatic logic cont_ok(logic [7:0] lead, logic [1:0] pos, logic [7:0] b);
        if ((b & B_CONT_MASK) != B_CONT_TAG) return 1'b0;
        if (pos == 2'd1) begin
            if (lead == B_LEAD3   && b <= B_HI_9F) return 1'b0;
            if (lead == B_LEAD_ED && b >  B_HI_9F) return 1'b0;
            if (lead == B_LEAD4   && b <= B_HI_8F) return 1'b0;
            if (lead == B_LEAD_F4 && b >= B_HI_90) return 1'b0;
        end
        return 1'b1;
    endfunction

    // One accepted byte (or end mark) -> expected codepoints
    function automatic void decode_byte(logic [7:0] b, logic eos);
        logic [7:0]       lead;
        logic [SUM_W-1:0] cp_sum;
        int               need;
        run_n = 0;
        if (eos) begin
            flush_pend();
            put_cp('0, 1'b0, 1'b1);
        end else if (pend_n == 2'd0) begin
            take_lead(b);
        end else begin
            lead = pend_b[0];
            if (cont_ok(lead, pend_n, b)) begin
                need = (lead < B_LEAD3) ? 2 : (lead < B_LEAD4) ? 3 : 4;
                if (int'(pend_n) + 1 == need) begin
                    case (need)
                        2: cp_sum = (SUM_W'(lead) << 6) + SUM_W'(b) - CP2_OFS;
                        3: cp_sum = (SUM_W'(lead) << 12) + (SUM_W'(pend_b[1]) << 6)
                                    + SUM_W'(b) - CP3_OFS;
                        default: cp_sum = (SUM_W'(lead) << 18) + (SUM_W'(pend_b[1]) << 12)
                                          + (SUM_W'(pend_b[2]) << 6) + SUM_W'(b) - CP4_OFS;
                    endcase
                    pend_n = 2'd0;
                    put_cp(cp_sum[CP_W-1:0], 1'b0, 1'b0);
                end else begin
                    pend_b[pend_n] = b;
                    pend_n++;
                end
            end else begin
                flush_pend();
                take_lead(b);
            end
        end
        for (int i = 0; i < run_n; i++) begin
            if (i == run_n - 1) run_buf[i].last = 1'b1;
            cp_due_q.push_back(run_buf[i]);
        end
    endfunction

    // ---------------- stimulus ----------------

    task automatic add_item(logic [7:0] b, logic eos, idle_mode_e m);
        byte_q.push_back('{b: b, eos: eos, mode: m});
    endtask

    // Well-formed multi-byte sequence, or a prefix of one followed by a random byte
    task automatic add_seq(idle_mode_e m, logic broken);
        int         len;
        int         cut;
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        len = $urandom_range(2, 4);
        case (len)
            2:       lead = B_LEAD_MIN + 8'd1 + 8'($urandom_range(0, 29));
            3:       lead = B_LEAD3 + 8'($urandom_range(0, 15));
            default: lead = B_LEAD4 + 8'($urandom_range(0, 4));
        endcase
        lo = B_CONT_TAG;
        hi = B_CONT_TAG + 8'h3F;
        if (lead == B_LEAD3)        lo = B_HI_9F + 8'd1;
        else if (lead == B_LEAD_ED) hi = B_HI_9F;
        else if (lead == B_LEAD4)   lo = B_HI_90;
        else if (lead == B_LEAD_F4) hi = B_HI_8F;
        cut = broken ? $urandom_range(1, len - 1) : len;
        add_item(lead, 1'b0, m);
        for (int k = 1; k < cut; k++) begin
            if (k == 1) add_item(lo + 8'($urandom_range(0, hi - lo)), 1'b0, m);
            else        add_item(B_CONT_TAG + 8'($urandom_range(0, 63)), 1'b0, m);
        end
        if (broken) add_item(8'($urandom_range(0, 255)), 1'b0, m);
    endtask

    task automatic add_random_phase(idle_mode_e m);
        int start;
        int pick;
        start = byte_q.size();
        while (byte_q.size() - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      add_item(8'($urandom_range(0, 127)), 1'b0, m);
            else if (pick < 70) add_seq(m, 1'b0);
            else if (pick < 80) add_item(8'($urandom_range(0, 255)), 1'b1, m);
            else if (pick < 90) add_seq(m, 1'b1);
            else                add_item(8'($urandom_range(0, 255)), 1'b0, m);
        end
    endtask

    initial begin
        // Directed: ASCII and invalid-lead extremes
        add_item(8'h00, 1'b0, IDLE_NONE);
        add_item(8'hFF, 1'b0, IDLE_NONE);
        // Shortest two-byte lead, top continuation
        add_item(8'hC2, 1'b0, IDLE_NONE);
        add_item(8'hBF, 1'b0, IDLE_NONE);
        // Second-byte limits broken after E0, ED, F0, F4
        add_item(8'hE0, 1'b0, IDLE_NONE);
        add_item(8'h9F, 1'b0, IDLE_NONE);
        add_item(8'hED, 1'b0, IDLE_NONE);
        add_item(8'hA0, 1'b0, IDLE_NONE);
        add_item(8'hF0, 1'b0, IDLE_NONE);
        add_item(8'h8F, 1'b0, IDLE_NONE);
        // Highest scalar value U+10FFFF
        add_item(8'hF4, 1'b0, IDLE_NONE);
        add_item(8'h8F, 1'b0, IDLE_NONE);
        add_item(8'hBF, 1'b0, IDLE_NONE);
        add_item(8'hBF, 1'b0, IDLE_NONE);
        add_item(8'hF4, 1'b0, IDLE_NONE);
        add_item(8'h90, 1'b0, IDLE_NONE);
        // End mark with two bytes pending
        add_item(8'hE1, 1'b0, IDLE_NONE);
        add_item(8'h80, 1'b0, IDLE_NONE);
        add_item(8'hA5, 1'b1, IDLE_NONE);
        // Three pending bytes broken by ASCII: four results from one byte
        add_item(8'hF1, 1'b0, IDLE_NONE);
        add_item(8'h80, 1'b0, IDLE_NONE);
        add_item(8'h80, 1'b0, IDLE_NONE);
        add_item(8'h7F, 1'b0, IDLE_NONE);
        // Unassigned 1252 slot, overlong lead, bare end mark
        add_item(8'h8D, 1'b0, IDLE_NONE);
        add_item(8'hC1, 1'b0, IDLE_NONE);
        add_item(8'h5A, 1'b1, IDLE_NONE);

        add_random_phase(IDLE_NONE);
        add_random_phase(IDLE_SEND);
        add_random_phase(IDLE_RECV);
        add_random_phase(IDLE_BOTH);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_valid) @(posedge clk);
        while (cp_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_eos   <= 1'b0;
        end else begin
            // Completed transfer feeds the predictor
            if (in_valid && in_ready) begin
                decode_byte(in_byte, in_eos);
                n_taken <= n_taken + 1;
            end
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 &&
                    $urandom_range(0, 99) >= (byte_q[0].mode == IDLE_SEND ? 81 :
                                              byte_q[0].mode == IDLE_BOTH ? 19 : 0)) begin
                    in_valid  <= 1'b1;
                    in_byte   <= byte_q[0].b;
                    in_eos    <= byte_q[0].eos;
                    idle_mode <= byte_q[0].mode;
                    void'(byte_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering bytes
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_taken == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        cp_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (cp_due_q.size() == 0) begin
                    $error("unexpected result: codepoint %h", out_cp);
                    n_err++;
                end else begin
                    want = cp_due_q.pop_front();
                    if (out_cp !== want.cp) begin
                        $error("codepoint: expected %h, got %h", want.cp, out_cp);
                        n_err++;
                    end
                    if (out_fb !== want.fb) begin
                        $error("from_fallback: expected %b, got %b", want.fb, out_fb);
                        n_err++;
                    end
                    if (out_em !== want.em) begin
                        $error("end_marker: expected %b, got %b", want.em, out_em);
                        n_err++;
                    end
                    if (out_last !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, out_last);
                        n_err++;
                    end
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else
                out_ready <= $urandom_range(0, 99) >= (idle_mode == IDLE_RECV ? 81 :
                                                       idle_mode == IDLE_BOTH ? 19 : 0);
        end
    end

    // Run limit
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/ucf_pkg.sv
sv/utf8_decode_cp1252_fallback.sv
sv/ucf_checker.sv
bench/utf8_decode_cp1252_fallback_tb.sv
